[rtl/core/tipar_pkg.sv]
// Shared types, register indexes and the ones' complement adder used by the
// TCP/IP address rewriter. No dependencies.
package tipar_pkg;

  localparam logic [1:0] REG_NEW_ADDRESS  = 2'd0;
  localparam logic [1:0] REG_NEW_PORT     = 2'd1;
  localparam logic [1:0] REG_CHANGE_WHICH = 2'd2;

  localparam logic [15:0] WORD_COUNT_MAX = 16'h8000;
  localparam logic [3:0]  IP_VERSION     = 4'd4;
  localparam logic [3:0]  IHL_MIN        = 4'd5;
  localparam logic [6:0]  TCP_HDR_BYTES  = 7'd20;

  typedef struct packed {
    logic [31:0] new_address;
    logic [15:0] new_port;
    logic        change_which;
  } cfg_t;

  typedef struct packed {
    logic [15:0] out_word;
    logic        out_last;
    logic [15:0] ip_checksum;
    logic [15:0] tcp_checksum;
    logic        status;
  } result_t;

  // Adds one word to a running sum and folds the carry back in.
  function automatic logic [16:0] oc_add(logic [16:0] s, logic [15:0] w);
    logic [17:0] t;
    t = 18'(s) + 18'(w);
    return 17'(t[15:0]) + 17'(t[17:16]);
  endfunction

endpackage

[rtl/core/tipar_cfg.sv]
// Configuration registers of the TCP/IP address rewriter.
// Depends on tipar_pkg.
module tipar_cfg import tipar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NEW_ADDRESS:  cfg.new_address  <= cfg_wdata;
        REG_NEW_PORT:     cfg.new_port     <= cfg_wdata[15:0];
        REG_CHANGE_WHICH: cfg.change_which <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/tipar_core.sv]
// Per-packet state and the single-pass rewrite and checksum logic for one word.
// Depends on tipar_pkg.
module tipar_core import tipar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [15:0] word,
  input  logic        last,
  input  logic        half,
  input  cfg_t        cfg,
  output result_t     res
);

  logic [15:0] word_count;
  logic [3:0]  header_words;
  logic [15:0] total_length;
  logic [16:0] ip_sum;
  logic [16:0] tcp_sum;
  logic        malformed;

  logic [15:0] word_count_next;
  logic [3:0]  header_words_next;
  logic [15:0] total_length_next;
  logic [16:0] ip_sum_next;
  logic [16:0] tcp_sum_next;
  logic        malformed_next;

  logic [15:0] w;
  logic [15:0] o;
  logic [15:0] k;
  logic [15:0] hw2;
  logic [16:0] k2;
  logic [17:0] bytes;
  logic [15:0] seg;
  logic        mal_final;
  logic [16:0] tcp_final;

  always_comb begin
    k = word_count;
    w = (half && last) ? {word[15:8], 8'h00} : word;

    header_words_next = header_words;
    total_length_next = total_length;
    malformed_next    = malformed;
    if (k == 16'd0) begin
      header_words_next = w[11:8];
      if (w[15:12] != IP_VERSION || w[11:8] < IHL_MIN) malformed_next = 1'b1;
    end else if (k == 16'd1) begin
      total_length_next = w;
      if (w < 16'({header_words, 2'b00} + TCP_HDR_BYTES)) malformed_next = 1'b1;
    end
    hw2 = 16'({header_words_next, 1'b0});

    o = w;
    if (!malformed_next) begin
      if (k == 16'd5) o = '0;
      if (!cfg.change_which) begin
        if (k == 16'd6)      o = cfg.new_address[31:16];
        else if (k == 16'd7) o = cfg.new_address[15:0];
        else if (k == hw2)   o = cfg.new_port;
      end else begin
        if (k == 16'd8)              o = cfg.new_address[31:16];
        else if (k == 16'd9)         o = cfg.new_address[15:0];
        else if (k == hw2 + 16'd1)   o = cfg.new_port;
      end
      if (k == hw2 + 16'd8) o = '0;
    end

    ip_sum_next  = ip_sum;
    tcp_sum_next = tcp_sum;
    k2 = {k, 1'b0};
    if (k < hw2) begin
      ip_sum_next = oc_add(ip_sum, o);
      if (k >= 16'd6 && k <= 16'd9) tcp_sum_next = oc_add(tcp_sum, o);
      else if (k == 16'd4)          tcp_sum_next = oc_add(tcp_sum, {8'h00, o[7:0]});
    end else if (k2 < 17'(total_length_next)) begin
      if (k2 + 17'd1 == 17'(total_length_next))
        tcp_sum_next = oc_add(tcp_sum, {o[15:8], 8'h00});
      else
        tcp_sum_next = oc_add(tcp_sum, o);
    end

    word_count_next = (word_count < WORD_COUNT_MAX) ? word_count + 16'd1 : word_count;

    bytes     = 18'({k2 + 17'd2}) - 18'(half && last);
    mal_final = malformed_next || (bytes < 18'(total_length_next));
    seg       = total_length_next - 16'({header_words_next, 2'b00});
    tcp_final = oc_add(tcp_sum_next, seg);

    res.out_word     = o;
    res.out_last     = last;
    res.ip_checksum  = '0;
    res.tcp_checksum = '0;
    res.status       = 1'b0;
    if (last) begin
      res.status = mal_final;
      if (!mal_final) begin
        res.ip_checksum  = ~ip_sum_next[15:0];
        res.tcp_checksum = ~tcp_final[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count   <= '0;
      header_words <= '0;
      total_length <= '0;
      ip_sum       <= '0;
      tcp_sum      <= '0;
      malformed    <= 1'b0;
    end else if (fire) begin
      if (last) begin
        word_count   <= '0;
        header_words <= '0;
        total_length <= '0;
        ip_sum       <= '0;
        tcp_sum      <= '0;
        malformed    <= 1'b0;
      end else begin
        word_count   <= word_count_next;
        header_words <= header_words_next;
        total_length <= total_length_next;
        ip_sum       <= ip_sum_next;
        tcp_sum      <= tcp_sum_next;
        malformed    <= malformed_next;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (fire && last) |=> (word_count == '0 && !malformed && ip_sum == '0))
    else $error("packet state not cleared after last item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    word_count <= WORD_COUNT_MAX)
    else $error("word count beyond saturation limit");

  a_malformed_sticky: assert property (@(posedge clk) disable iff (rst)
    (malformed && !(fire && last)) |=> malformed)
    else $error("malformed flag dropped inside a packet");

  a_bad_status_zero: assert property (@(posedge clk) disable iff (rst)
    (fire && malformed && last) |-> (res.status && res.ip_checksum == '0
                                     && res.tcp_checksum == '0))
    else $error("malformed packet reported with checksums");

endmodule

[rtl/core/tcp_ip_address_rewriter_top.sv]
// Rewrites the source or destination address and port of an IPv4/TCP packet
// streamed as 16-bit words, zeroes both checksum fields and reports the new IP
// and TCP checksums with the last word. The block takes one item per clock
// while the output side takes one item per cycle: an input register feeds one
// pass of rewrite and sum logic into an output register, and a stalled output
// holds both registers. Configuration should be written while no packet is in
// flight. Depends on tipar_pkg, tipar_cfg and tipar_core.
module tcp_ip_address_rewriter_top import tipar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_word
  input  logic        s_tlast,
  input  logic        s_tuser,   // half_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_word, ip_checksum, tcp_checksum, status, zero pad
  output logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t        cfg;
  result_t     res;
  logic        in_valid;
  logic [15:0] in_word;
  logic        in_last;
  logic        in_half;
  logic        advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  tipar_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tipar_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .word (in_word),
    .last (in_last),
    .half (in_half),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_word <= s_tdata;
      in_last <= s_tlast;
      in_half <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
    if (advance) begin
      m_tdata <= {7'd0, res.status, res.tcp_checksum, res.ip_checksum, res.out_word};
      m_tlast <= res.out_last;
    end
  end

endmodule
